// ----- rtl/dedup_append_key_store_defines.svh -----
// assertion macros for the dedup append key store
// no dependencies; included by files that carry concurrent assertions
`ifndef DEDUP_APPEND_KEY_STORE_DEFINES_SVH
`define DEDUP_APPEND_KEY_STORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DKS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DKS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DKS_ASSERT_IMP(label, clk, rst, ante, cons)
`define DKS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/dks_pkg.sv -----
// shared constants, status codes and types of the dedup append key store
// no dependencies
package dks_pkg;
  localparam int KEY_SLOTS = 79;
  localparam int CNT_W     = 7;
  localparam int KEY_W     = 64;
  localparam int IDX_W     = 8;
  localparam int ADDR_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(KEY_SLOTS);
  localparam logic [IDX_W-1:0] SLOTS_IDX = IDX_W'(KEY_SLOTS);

  // item modes
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_DUP   = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // key memory request from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } dks_mem_req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic             fin;
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } dks_res_t;
endpackage

// ----- rtl/dks_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module dks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]                               wr_data,
  input  logic                                           rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
  output logic [WIDTH-1:0]                               rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- rtl/dks_ctrl.sv -----
// sequencer: holds the key count, runs the duplicate scan and slot reads
// depends on dks_pkg; drives the key memory request
module dks_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      mode,
  input  logic [dks_pkg::IDX_W-1:0] key_index,
  input  logic [dks_pkg::KEY_W-1:0] key_data,
  output logic                      busy,
  output dks_pkg::dks_mem_req_t     mem_req,
  input  logic [dks_pkg::KEY_W-1:0] rd_data,
  input  logic                      out_free,
  output dks_pkg::dks_res_t         res
);
  import dks_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RDW  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic             cmp_vld, cmp_vld_next;
  logic             cmp_last, cmp_last_next;
  logic [KEY_W-1:0] key, key_next;
  status_t          res_status, res_status_next;
  logic [KEY_W-1:0] res_key, res_key_next;
  logic [IDX_W-1:0] idx_m1;

  assign idx_m1 = key_index - IDX_W'(1);

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    cmp_vld_next    = 1'b0;
    cmp_last_next   = 1'b0;
    key_next        = key;
    res_status_next = res_status;
    res_key_next    = res_key;
    mem_req         = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_READ) begin
            if (key_index == '0 || key_index > SLOTS_IDX) begin
              res_status_next = ST_RANGE;
              res_key_next    = '0;
              state_next      = S_FIN;
            end else if ({1'b0, count} >= key_index) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = idx_m1[ADDR_W-1:0];
              state_next      = S_RDW;
            end else begin
              // slot never written since reset
              res_status_next = ST_OK;
              res_key_next    = '0;
              state_next      = S_FIN;
            end
          end else begin
            key_next     = key_data;
            res_key_next = '0;
            if (count == SLOTS_CNT) begin
              res_status_next = ST_FULL;
              state_next      = S_FIN;
            end else if (count == '0) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = '0;
              mem_req.wr_data = key_data;
              count_next      = CNT_W'(1);
              res_status_next = ST_OK;
              state_next      = S_FIN;
            end else begin
              ptr_next   = '0;
              state_next = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld && rd_data == key) begin
          res_status_next = ST_DUP;
          state_next      = S_FIN;
        end else if (cmp_vld && cmp_last) begin
          // no match in slots 1..count: append
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = count[ADDR_W-1:0];
          mem_req.wr_data = key;
          count_next      = count + CNT_W'(1);
          res_status_next = ST_OK;
          state_next      = S_FIN;
        end else if (ptr < count) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr[ADDR_W-1:0];
          cmp_vld_next    = 1'b1;
          cmp_last_next   = (ptr == count - CNT_W'(1));
          ptr_next        = ptr + CNT_W'(1);
        end
      end
      S_RDW: begin
        res_status_next = ST_OK;
        res_key_next    = rd_data;
        state_next      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cmp_vld  <= 1'b0;
      cmp_last <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cmp_vld  <= cmp_vld_next;
      cmp_last <= cmp_last_next;
    end
    ptr        <= ptr_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
  end

  assign busy       = (state != S_IDLE);
  assign res.fin    = (state == S_FIN);
  assign res.status = res_status;
  assign res.key    = res_key;
  assign res.count  = count;
endmodule

// ----- rtl/dedup_append_key_store.sv -----
// Deduplicating append-only store of up to KEY_SLOTS (79) 64-bit keys in
// slots 1..KEY_SLOTS, kept in one synchronous ram with a registered read.
// mode 0 adds key_data: refused with status 1 when the store is full, with
// status 2 when the key already sits in slots 1..count, else appended at
// slot count+1. mode 1 reads slot key_index; index 0 or above KEY_SLOTS
// gives status 3. Every item gives one result carrying the count after it.
// One item at a time: an add to a non-empty store reads the stored keys from
// the ram one by one, compares each with the new key and stops at the first
// match; after the last compare with no match it appends, then finishes. A
// read of a written slot does one ram read and then finishes; a full-store
// add, an add to the empty store or any other read finishes at once. The
// result waits until the output register is free; the sequencer is idle
// again as soon as the result is loaded. The scan over the key ram is what
// sets the add time. Reset clears only the count and the sequencer state:
// slots are only ever written in order, so a slot above the count reads as
// zero without touching the ram, and no clearing pass is needed. A finished
// result waits in the output register while the next item is already taken.
// depends on dks_pkg, dks_ctrl, dks_ram and dedup_append_key_store_defines.svh
`include "dedup_append_key_store_defines.svh"
module dedup_append_key_store (
  input  logic                      clk,
  input  logic                      rst,
  // input item channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic [dks_pkg::IDX_W-1:0] key_index,
  input  logic [dks_pkg::KEY_W-1:0] key_data,
  // result item channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output dks_pkg::status_t          status,
  output logic [dks_pkg::KEY_W-1:0] key_out,
  output logic [dks_pkg::CNT_W-1:0] key_count
);
  import dks_pkg::*;

  logic             busy;
  logic             out_free;
  dks_mem_req_t     mem_req;
  dks_res_t         res;
  logic [KEY_W-1:0] rd_data;

  // a new item is taken whenever the sequencer is idle
  assign in_stall = busy;

  // output register frees up when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  dks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .key_index (key_index),
    .key_data  (key_data),
    .busy      (busy),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .out_free  (out_free),
    .res       (res)
  );

  // key slots: slot n lives at ram address n-1
  dks_ram #(
    .WIDTH (KEY_W),
    .DEPTH (KEY_SLOTS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.fin && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res.fin && out_free) begin
      status    <= res.status;
      key_out   <= res.key;
      key_count <= res.count;
    end
  end

  // refused or out-of-range items never carry a key
  `DKS_ASSERT_IMP(a_key_zero, clk, rst, out_valid && status != ST_OK, key_out == '0)
  // a full refusal only happens at capacity
  `DKS_ASSERT_IMP(a_full_cnt, clk, rst, out_valid && status == ST_FULL, key_count == SLOTS_CNT)
  // the count never exceeds the slot count
  `DKS_ASSERT_IMP(a_cnt_max, clk, rst, out_valid, key_count <= SLOTS_CNT)
  // an accepted item keeps the sequencer busy in the next cycle
  `DKS_ASSERT_NXT(a_busy, clk, rst, in_valid && !in_stall, in_stall)
endmodule
